// ===== rtl/xcfd_pkg.sv =====
package xcfd_pkg;

  localparam int unsigned MaxFrameBytesDef = 1024;
  localparam int unsigned QueueDepth       = 4;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned CodeW            = 7;
  localparam int unsigned LenW             = 10;
  localparam int unsigned CfgIdxW          = 3;

  localparam logic [ByteW-1:0] StartMarkerRst  = 8'h02;
  localparam logic [ByteW-1:0] EndMarkerRst    = 8'h03;
  localparam logic [ByteW-1:0] OpcodeLowRst    = 8'h80;
  localparam logic [ByteW-1:0] OpcodeHighRst   = 8'hB6;
  localparam logic [ByteW-1:0] SecureOpcodeRst = 8'hB5;

  localparam logic [ByteW-1:0] CkForceMask = 8'h80;
  localparam logic [ByteW-1:0] Low7Mask    = 8'h7F;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker  = 3'd0,
    CfgEndMarker    = 3'd1,
    CfgOpcodeLow    = 3'd2,
    CfgOpcodeHigh   = 3'd3,
    CfgSecureOpcode = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOkData     = 3'd0,
    StOkNoData   = 3'd1,
    StSecure     = 3'd2,
    StBadMarker  = 3'd3,
    StBadCheck   = 3'd4,
    StShort      = 3'd5,
    StTooLong    = 3'd6
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
    logic [ByteW-1:0] opcode_low;
    logic [ByteW-1:0] opcode_high;
    logic [ByteW-1:0] secure_opcode;
  } cfg_t;

  // One classified byte: an optional tentative payload byte and an optional verdict.
  typedef struct packed {
    logic             has_byte;
    logic [CodeW-1:0] data;
    logic             has_verdict;
    status_e          status;
    logic [CodeW-1:0] area;
    logic [CodeW-1:0] controller;
    logic [CodeW-1:0] subcontroller;
    logic [ByteW-1:0] opcode;
    logic [LenW-1:0]  plen;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [CodeW-1:0] payload_byte;
    status_e          status;
    logic [CodeW-1:0] area;
    logic [CodeW-1:0] controller;
    logic [CodeW-1:0] subcontroller;
    logic [ByteW-1:0] opcode;
    logic [LenW-1:0]  plen;
    logic             run_last;
  } result_t;

endpackage

// ===== rtl/xcfd_front.sv =====
module xcfd_front #(
  parameter int unsigned MAX_FRAME_BYTES = xcfd_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xcfd_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [xcfd_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          frame_end_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output xcfd_pkg::req_t                req_o
);
  import xcfd_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] dl_q [2];
  logic [ByteW-1:0] dl_d [2];
  logic [CodeW-1:0] addr_q [3];
  logic [CodeW-1:0] addr_d [3];
  logic [ByteW-1:0] op_q, op_d;
  logic             start_q, start_d;
  logic             accept;
  logic [1:0]       addr_idx;
  logic [PosW:0]    len_diff;
  logic             in_range;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign addr_idx   = 2'(pos_q - PosW'(1));
  assign len_diff   = {1'b0, pos_q} - (PosW + 1)'(6);
  assign in_range   = (op_d >= cfg_i.opcode_low) && (op_d <= cfg_i.opcode_high);

  always_comb begin
    xor_d   = xor_q;
    start_d = start_q;
    addr_d  = addr_q;
    op_d    = op_q;
    if (pos_q >= PosW'(3)) begin
      xor_d = xor_q ^ dl_q[1];
    end
    if (pos_q == '0) begin
      start_d = (in_byte_i == cfg_i.start_marker);
    end else if (pos_q <= PosW'(3)) begin
      addr_d[addr_idx] = in_byte_i[CodeW-1:0];
    end else if (pos_q == PosW'(4)) begin
      op_d = in_byte_i;
    end
    dl_d[1] = dl_q[0];
    dl_d[0] = in_byte_i;
    pos_d   = (pos_q < PosW'(MAX_FRAME_BYTES)) ? pos_q + PosW'(1) : pos_q;
  end

  // Classify the byte into a request for the back end.
  always_comb begin
    req_o               = '0;
    req_o.has_byte      = (pos_q >= PosW'(7));
    req_o.data          = dl_q[1][CodeW-1:0];
    req_o.has_verdict   = frame_end_i;
    req_o.area          = addr_d[0];
    req_o.controller    = addr_d[1];
    req_o.subcontroller = addr_d[2];
    req_o.opcode        = op_d;
    if (pos_q < PosW'(6)) begin
      req_o.status = StShort;
    end else if (!start_d || (in_byte_i != cfg_i.end_marker)) begin
      req_o.status = StBadMarker;
    end else if (dl_q[0] != ((~xor_d) | CkForceMask)) begin
      req_o.status = StBadCheck;
    end else if (pos_q >= PosW'(MAX_FRAME_BYTES)) begin
      req_o.status = StTooLong;
    end else if (op_d == cfg_i.secure_opcode) begin
      req_o.status = StSecure;
    end else if (in_range && (pos_q > PosW'(6))) begin
      req_o.status = StOkData;
      req_o.plen   = LenW'(len_diff);
    end else begin
      req_o.status = StOkNoData;
    end
  end

  assign push_o = accept && (req_o.has_byte || frame_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      xor_q   <= '0;
      dl_q    <= '{default: '0};
      addr_q  <= '{default: '0};
      op_q    <= '0;
      start_q <= 1'b0;
    end else if (accept) begin
      if (frame_end_i) begin
        pos_q   <= '0;
        xor_q   <= '0;
        dl_q    <= '{default: '0};
        addr_q  <= '{default: '0};
        op_q    <= '0;
        start_q <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        xor_q   <= xor_d;
        dl_q    <= dl_d;
        addr_q  <= addr_d;
        op_q    <= op_d;
        start_q <= start_d;
      end
    end
  end

endmodule

// ===== rtl/xcfd_queue.sv =====
module xcfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcfd_pkg::req_t req_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output xcfd_pkg::req_t head_o
);
  import xcfd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= PtrW'(wr_q + PtrW'(1));
      end
      if (do_pop) begin
        rd_q <= PtrW'(rd_q + PtrW'(1));
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/xcfd_back.sv =====
module xcfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  xcfd_pkg::req_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xcfd_pkg::result_t res_o
);
  import xcfd_pkg::*;

  // Set once the tentative byte of a two-result request has gone out.
  logic byte_sent_q;
  logic show_byte;
  logic taken;

  assign show_byte   = head_i.has_byte && !byte_sent_q;
  assign out_valid_o = head_valid_i;
  assign taken       = head_valid_i && out_ready_i;
  assign pop_o       = taken && !(show_byte && head_i.has_verdict);

  always_comb begin
    res_o = '0;
    if (show_byte) begin
      res_o.payload_byte = head_i.data;
    end else begin
      res_o.kind          = 1'b1;
      res_o.status        = head_i.status;
      res_o.area          = head_i.area;
      res_o.controller    = head_i.controller;
      res_o.subcontroller = head_i.subcontroller;
      res_o.opcode        = head_i.opcode;
      res_o.plen          = head_i.plen;
      res_o.run_last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_sent_q <= 1'b0;
    end else if (taken) begin
      byte_sent_q <= !pop_o;
    end
  end

endmodule

// ===== rtl/xor_checked_frame_deframer.sv =====
// A request is written into the queue before its first result is offered.
// Throughput: one byte per cycle while the queue is not full; the last byte of a
//   frame of eight or more bytes yields two results, and the extra output is
//   absorbed by the four-entry queue between front and back end.
// Reset: asynchronous, active low; clears frame state, queue and the
//   configuration registers to their defaults.
module xor_checked_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = xcfd_pkg::MaxFrameBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [xcfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xcfd_pkg::ByteW-1:0]   cfg_data_i,
  // Byte input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [xcfd_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         frame_end_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic [xcfd_pkg::CodeW-1:0]   payload_byte_o,
  output logic [2:0]                   frame_status_o,
  output logic [xcfd_pkg::CodeW-1:0]   area_code_o,
  output logic [xcfd_pkg::CodeW-1:0]   controller_code_o,
  output logic [xcfd_pkg::CodeW-1:0]   subcontroller_code_o,
  output logic [xcfd_pkg::ByteW-1:0]   opcode_out_o,
  output logic [xcfd_pkg::LenW-1:0]    payload_len_o,
  output logic                         run_last_o
);
  import xcfd_pkg::*;

  cfg_t    cfg_q;
  req_t    push_req;
  req_t    head_req;
  result_t res;
  logic    push;
  logic    q_full;
  logic    head_valid;
  logic    pop;

  // Configuration is always taken; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker  <= StartMarkerRst;
      cfg_q.end_marker    <= EndMarkerRst;
      cfg_q.opcode_low    <= OpcodeLowRst;
      cfg_q.opcode_high   <= OpcodeHighRst;
      cfg_q.secure_opcode <= SecureOpcodeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgStartMarker:  cfg_q.start_marker  <= cfg_data_i;
        CfgEndMarker:    cfg_q.end_marker    <= cfg_data_i;
        CfgOpcodeLow:    cfg_q.opcode_low    <= cfg_data_i;
        CfgOpcodeHigh:   cfg_q.opcode_high   <= cfg_data_i;
        CfgSecureOpcode: cfg_q.secure_opcode <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: track frame position, XOR, delay line and header; classify each byte.
  xcfd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .req_o       (push_req)
  );

  // Decouple the byte side from the result side.
  xcfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_req)
  );

  // Back end: expand each request into a tentative byte, a verdict, or both.
  xcfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_req),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign result_kind_o        = res.kind;
  assign payload_byte_o       = res.payload_byte;
  assign frame_status_o       = res.status;
  assign area_code_o          = res.area;
  assign controller_code_o    = res.controller;
  assign subcontroller_code_o = res.subcontroller;
  assign opcode_out_o         = res.opcode;
  assign payload_len_o        = res.plen;
  assign run_last_o           = res.run_last;

endmodule
